// File: sv/jsud_pkg.sv
// Shared types, codes and helper functions for the JSON string unescape decoder.
package jsud_pkg;

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_U         = 8'h75;

  localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0]  UTF8_CONT  = 8'h80;
  localparam logic [5:0]  UTF8_MASK  = 6'h3F;
  localparam logic [15:0] CP_TWO_MIN   = 16'h0080;
  localparam logic [15:0] CP_THREE_MIN = 16'h0800;

  localparam int FIFO_DEPTH = 4;

  typedef enum logic [1:0] {
    PH_WAIT,
    PH_STR,
    PH_ESC,
    PH_HEX
  } phase_t;

  typedef enum logic [2:0] {
    ST_DATA       = 3'd0,
    ST_DONE       = 3'd1,
    ST_UNTERM_STR = 3'd2,
    ST_UNTERM_ESC = 3'd3,
    ST_BAD_ESC    = 3'd4,
    ST_BAD_UNI    = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] out_byte;
    status_t    status;
    logic       last_of_run;
  } res_t;

  typedef struct packed {
    phase_t          phase_nxt;
    logic [1:0]      hex_cnt_nxt;
    logic [15:0]     cp_nxt;
    logic [1:0]      count;
    res_t [2:0]      res;
  } dec_t;

  // Returns {valid, digit value}.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    case (c) inside
      [8'h30:8'h39]: r = {1'b1, 4'(c - 8'h30)};
      [8'h41:8'h46]: r = {1'b1, 4'(c - 8'h37)};
      [8'h61:8'h66]: r = {1'b1, 4'(c - 8'h57)};
      default:       r = '0;
    endcase
    return r;
  endfunction

  // Returns {valid, mapped byte} for the single-letter escapes.
  function automatic logic [8:0] simple_escape(input logic [7:0] e);
    logic [8:0] r;
    r = '0;
    case (e)
      8'h22:   r = {1'b1, 8'h22};
      8'h5C:   r = {1'b1, 8'h5C};
      8'h2F:   r = {1'b1, 8'h2F};
      8'h6E:   r = {1'b1, 8'h0A};
      8'h74:   r = {1'b1, 8'h09};
      8'h72:   r = {1'b1, 8'h0D};
      8'h62:   r = {1'b1, 8'h08};
      8'h66:   r = {1'b1, 8'h0C};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: sv/jsud_in_if.sv
// Input channel: one raw JSON text byte or an end-of-text mark per transfer.
interface jsud_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

// File: sv/jsud_out_if.sv
// Result channel: one decoded byte or status code per transfer.
interface jsud_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] status;
  logic       last_of_run;

  modport source (output valid, output out_byte, output status, output last_of_run,
                  input ready);
  modport sink   (input valid, input out_byte, input status, input last_of_run,
                  output ready);
endinterface

// File: sv/jsud_decode.sv
// Combinational decode of one input byte against the current parser state.
module jsud_decode (
  input  jsud_pkg::phase_t phase,
  input  logic [1:0]       hex_cnt,
  input  logic [15:0]      cp,
  input  logic [7:0]       in_byte,
  input  logic             end_of_text,
  output jsud_pkg::dec_t   dec
);
  import jsud_pkg::*;

  logic [4:0]  hex;
  logic [8:0]  esc;
  logic [15:0] cp_new;

  assign hex    = hex_value(in_byte);
  assign esc    = simple_escape(in_byte);
  assign cp_new = {cp[11:0], hex[3:0]};

  always_comb begin
    dec           = '0;
    dec.phase_nxt = phase;
    dec.hex_cnt_nxt = hex_cnt;
    dec.cp_nxt    = cp;
    for (int k = 0; k < 3; k++) begin
      dec.res[k].status = ST_DATA;
    end

    case (phase)
      PH_STR: begin
        if (end_of_text) begin
          dec.res[0].status = ST_UNTERM_STR;
          dec.count = 2'd1;
          dec.phase_nxt = PH_WAIT;
        end else if (in_byte == CH_QUOTE) begin
          dec.res[0].status = ST_DONE;
          dec.count = 2'd1;
          dec.phase_nxt = PH_WAIT;
        end else if (in_byte == CH_BACKSLASH) begin
          dec.phase_nxt = PH_ESC;
        end else begin
          dec.res[0].out_byte = in_byte;
          dec.count = 2'd1;
        end
      end

      PH_ESC: begin
        if (end_of_text) begin
          dec.res[0].status = ST_UNTERM_ESC;
          dec.count = 2'd1;
          dec.phase_nxt = PH_WAIT;
        end else if (in_byte == CH_U) begin
          dec.phase_nxt   = PH_HEX;
          dec.hex_cnt_nxt = 2'd0;
          dec.cp_nxt      = '0;
        end else if (!esc[8]) begin
          dec.res[0].status = ST_BAD_ESC;
          dec.count = 2'd1;
          dec.phase_nxt = PH_WAIT;
        end else begin
          dec.res[0].out_byte = esc[7:0];
          dec.count = 2'd1;
          dec.phase_nxt = PH_STR;
        end
      end

      PH_HEX: begin
        if (end_of_text || !hex[4]) begin
          dec.res[0].status = ST_BAD_UNI;
          dec.count = 2'd1;
          dec.phase_nxt = PH_WAIT;
        end else if (hex_cnt != 2'd3) begin
          dec.cp_nxt      = cp_new;
          dec.hex_cnt_nxt = hex_cnt + 2'd1;
        end else begin
          // Fourth digit: emit the code point as UTF-8.
          dec.phase_nxt = PH_STR;
          if (cp_new < CP_TWO_MIN) begin
            dec.res[0].out_byte = cp_new[7:0];
            dec.count = 2'd1;
          end else if (cp_new < CP_THREE_MIN) begin
            dec.res[0].out_byte = UTF8_LEAD2 | {3'b000, cp_new[10:6]};
            dec.res[1].out_byte = UTF8_CONT | {2'b00, cp_new[5:0] & UTF8_MASK};
            dec.count = 2'd2;
          end else begin
            dec.res[0].out_byte = UTF8_LEAD3 | {4'b0000, cp_new[15:12]};
            dec.res[1].out_byte = UTF8_CONT | {2'b00, cp_new[11:6] & UTF8_MASK};
            dec.res[2].out_byte = UTF8_CONT | {2'b00, cp_new[5:0] & UTF8_MASK};
            dec.count = 2'd3;
          end
        end
      end

      default: begin
        if (!end_of_text && in_byte == CH_QUOTE) begin
          dec.phase_nxt = PH_STR;
        end
      end
    endcase

    // Leaving the escape digits, or any return to waiting, clears the collector.
    if (dec.phase_nxt != PH_HEX) begin
      dec.hex_cnt_nxt = 2'd0;
      dec.cp_nxt      = '0;
    end

    for (int k = 0; k < 3; k++) begin
      dec.res[k].last_of_run = (dec.count == 2'(k + 1));
    end
  end

endmodule

// File: sv/json_string_unescape_decoder_core.sv
// Top level of the JSON string unescape decoder: parser state and result queue.
//
//   channel  direction  payload                          transfer when
//   in_ch    in         in_byte, end_of_text             valid && ready
//   out_ch   out        out_byte, status, last_of_run    valid && ready
//
// One input byte is taken per cycle while at most one result waits in the queue.
// A byte is decoded in the cycle it is taken; its results go into the registered
// queue and leave on out_ch one per cycle while out_ch.ready is high. A three-byte
// UTF-8 sequence holds the input off until at most one result waits; this ready
// threshold leaves room in the four-entry queue for the next byte's three results.
// in_ch.ready depends only on registered state, never on out_ch.ready.
// Synchronous active-low reset returns to waiting for the opening quote.
module json_string_unescape_decoder_core (
  input logic       clk,
  input logic       rst_n,
  jsud_in_if.sink   in_ch,
  jsud_out_if.source out_ch
);
  import jsud_pkg::*;

  phase_t      phase_r;
  logic [1:0]  hex_cnt_r;
  logic [15:0] cp_r;
  dec_t        dec;

  res_t [FIFO_DEPTH-1:0] fifo_r, fifo_nxt, fifo_sh;
  logic [2:0]  cnt_r, cnt_nxt, base;
  logic        push, pop;
  logic [1:0]  n_push;

  jsud_decode u_decode (
    .phase       (phase_r),
    .hex_cnt     (hex_cnt_r),
    .cp          (cp_r),
    .in_byte     (in_ch.in_byte),
    .end_of_text (in_ch.end_of_text),
    .dec         (dec)
  );

  assign in_ch.ready        = (cnt_r <= 3'd1);
  assign out_ch.valid       = (cnt_r != 3'd0);
  assign out_ch.out_byte    = fifo_r[0].out_byte;
  assign out_ch.status      = fifo_r[0].status;
  assign out_ch.last_of_run = fifo_r[0].last_of_run;

  assign push   = in_ch.valid && in_ch.ready;
  assign pop    = out_ch.valid && out_ch.ready;
  assign n_push = push ? dec.count : 2'd0;
  assign base   = cnt_r - {2'b00, pop};

  always_comb begin
    fifo_sh = pop ? {fifo_r[FIFO_DEPTH-1], fifo_r[FIFO_DEPTH-1:1]} : fifo_r;
    for (int i = 0; i < FIFO_DEPTH; i++) begin
      logic [2:0] off;
      off = 3'(i) - base;
      if (3'(i) < base) begin
        fifo_nxt[i] = fifo_sh[i];
      end else if (off < {1'b0, n_push}) begin
        fifo_nxt[i] = dec.res[off[1:0]];
      end else begin
        fifo_nxt[i] = fifo_sh[i];
      end
    end
    cnt_nxt = base + {1'b0, n_push};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_WAIT;
      hex_cnt_r <= 2'd0;
      cp_r      <= '0;
      cnt_r     <= 3'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        phase_r   <= dec.phase_nxt;
        hex_cnt_r <= dec.hex_cnt_nxt;
        cp_r      <= dec.cp_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    fifo_r <= fifo_nxt;
  end

endmodule

// File: test/tb_json_string_unescape_decoder_core.sv
// Self-checking testbench for the JSON string unescape decoder core.
module tb_json_string_unescape_decoder_core;
  timeunit 1ns;
  timeprecision 1ps;

  import jsud_pkg::*;

  localparam int ITEM_TARGET  = 310;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;
  // The eight single-letter escapes: " \ / n t r b f
  localparam logic [63:0] ESC_LETTERS = {8'h22, 8'h5C, 8'h2F, 8'h6E,
                                         8'h74, 8'h72, 8'h62, 8'h66};

  logic clk = 1'b0;
  logic rst_n;

  jsud_in_if  in_ch ();
  jsud_out_if out_ch ();

  json_string_unescape_decoder_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #1 clk = ~clk;

  // Decoder state as predicted from the accepted bytes.
  phase_t      parse_phase;
  logic [1:0]  hex_count;
  logic [15:0] cp_acc;
  res_t        decoded_q [$];

  int burst_left;
  int sent_count;
  int noise_count;
  int results_checked;
  int mismatch_count;
  int strings_closed;
  int error_exits;
  int multibyte_seqs;
  int drains;
  int cycle_count;
  int stall_mode;

  // Returns {valid, value} for an ASCII hex digit.
  function automatic logic [4:0] hex_digit_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};
    if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h41 + 8'd10)};
    if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h61 + 8'd10)};
    return 5'b0;
  endfunction

  // Returns {valid, byte} for the letter that follows a backslash.
  function automatic logic [8:0] escape_target(input logic [7:0] e);
    case (e)
      8'h22:   return {1'b1, 8'h22};
      8'h5C:   return {1'b1, 8'h5C};
      8'h2F:   return {1'b1, 8'h2F};
      8'h6E:   return {1'b1, 8'h0A};
      8'h74:   return {1'b1, 8'h09};
      8'h72:   return {1'b1, 8'h0D};
      8'h62:   return {1'b1, 8'h08};
      8'h66:   return {1'b1, 8'h0C};
      default: return 9'b0;
    endcase
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return 8'h30 + 8'(nib);
    return (($urandom_range(0, 1) == 0) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
  endfunction

  function automatic void push_result(input logic [7:0] b, input status_t st,
                                      input logic last);
    res_t r;
    r.out_byte    = b;
    r.status      = st;
    r.last_of_run = last;
    decoded_q = {decoded_q, r};
  endfunction

  // Works out the results that one accepted item causes.
  task automatic decode_step(input logic [7:0] b, input logic eot);
    logic [7:0] utf [$];
    logic [4:0] hv;
    logic [8:0] esc;
    logic       is_err;
    status_t    err;
    is_err = 1'b0;
    err    = ST_DATA;
    case (parse_phase)
      PH_STR: begin
        if (eot) begin
          is_err = 1'b1;
          err    = ST_UNTERM_STR;
        end else if (b == CH_QUOTE) begin
          is_err = 1'b1;
          err    = ST_DONE;
        end else if (b == CH_BACKSLASH) begin
          parse_phase = PH_ESC;
        end else begin
          utf = {utf, b};
        end
      end
      PH_ESC: begin
        esc = escape_target(b);
        if (eot) begin
          is_err = 1'b1;
          err    = ST_UNTERM_ESC;
        end else if (b == CH_U) begin
          parse_phase = PH_HEX;
          hex_count   = 2'd0;
          cp_acc      = 16'd0;
        end else if (!esc[8]) begin
          is_err = 1'b1;
          err    = ST_BAD_ESC;
        end else begin
          parse_phase = PH_STR;
          utf = {utf, esc[7:0]};
        end
      end
      PH_HEX: begin
        hv = hex_digit_of(b);
        if (eot || !hv[4]) begin
          is_err = 1'b1;
          err    = ST_BAD_UNI;
        end else begin
          cp_acc = {cp_acc[11:0], hv[3:0]};
          if (hex_count != 2'd3) begin
            hex_count = hex_count + 2'd1;
          end else begin
            if (cp_acc < CP_TWO_MIN) begin
              utf = {utf, cp_acc[7:0]};
            end else if (cp_acc < CP_THREE_MIN) begin
              utf = {utf, UTF8_LEAD2 | {3'b0, cp_acc[10:6]}};
              utf = {utf, UTF8_CONT | {2'b0, cp_acc[5:0]}};
            end else begin
              utf = {utf, UTF8_LEAD3 | {4'b0, cp_acc[15:12]}};
              utf = {utf, UTF8_CONT | {2'b0, cp_acc[11:6]}};
              utf = {utf, UTF8_CONT | {2'b0, cp_acc[5:0]}};
            end
            if (utf.size() > 1) multibyte_seqs++;
            parse_phase = PH_STR;
            hex_count   = 2'd0;
            cp_acc      = 16'd0;
          end
        end
      end
      default: begin
        if (!eot && b == CH_QUOTE) begin
          parse_phase = PH_STR;
          hex_count   = 2'd0;
          cp_acc      = 16'd0;
        end
      end
    endcase
    if (is_err) begin
      parse_phase = PH_WAIT;
      hex_count   = 2'd0;
      cp_acc      = 16'd0;
      if (err == ST_DONE) strings_closed++;
      else error_exits++;
      push_result(8'h00, err, 1'b1);
    end else begin
      foreach (utf[i]) push_result(utf[i], ST_DATA, i == utf.size() - 1);
    end
  endtask

  // Sends one item; valid stays high between items of one burst.
  task automatic send_text(input logic [7:0] b, input logic eot);
    if (burst_left == 0) burst_left = ($urandom_range(0, 4) == 0) ? 48 : $urandom_range(1, 12);
    in_ch.valid       <= 1'b1;
    in_ch.in_byte     <= b;
    in_ch.end_of_text <= eot;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    decode_step(b, eot);
    sent_count++;
    burst_left--;
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_text(s[i], 1'b0);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    drains++;
  endtask

  task automatic test_waiting_phase();
    send_str("A");
    send_text(8'($urandom), 1'b1);
    send_str("\"");
  endtask

  task automatic test_plain_and_escapes();
    send_text(8'h00, 1'b0);
    send_text(8'hFF, 1'b0);
    send_str("\\n\"");
  endtask

  task automatic test_unicode_escapes();
    // Code point zero, then a lone surrogate that still encodes as three bytes.
    send_str("\"\\u0000\\uD800\"");
  endtask

  task automatic test_error_paths();
    send_str("\"\\u1g");
    send_str("\"\\uA");
    send_text(8'h00, 1'b1);
    send_str("\"\\");
    send_text(8'hFF, 1'b1);
    send_str("\"\\q");
    send_str("\"");
    send_text(8'h55, 1'b1);
  endtask

  task automatic send_random_string();
    int          n_elems;
    int          kind;
    int          brk;
    int          digits;
    logic [7:0]  b;
    logic [15:0] cp;
    send_text(CH_QUOTE, 1'b0);
    n_elems = $urandom_range(0, 8);
    for (int i = 0; i < n_elems; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        do b = 8'($urandom); while (b == CH_QUOTE || b == CH_BACKSLASH);
        send_text(b, 1'b0);
      end else if (kind < 75) begin
        send_text(CH_BACKSLASH, 1'b0);
        send_text(ESC_LETTERS[8 * $urandom_range(0, 7) +: 8], 1'b0);
      end else begin
        case ($urandom_range(0, 2))
          0:       cp = 16'($urandom_range(0, 16'h7F));
          1:       cp = 16'($urandom_range(16'h80, 16'h7FF));
          default: cp = 16'($urandom);
        endcase
        send_text(CH_BACKSLASH, 1'b0);
        send_text(CH_U, 1'b0);
        for (int k = 3; k >= 0; k--) send_text(hex_char(cp[k * 4 +: 4]), 1'b0);
      end
    end
    brk = $urandom_range(0, 99);
    if (brk < 80) begin
      send_text(CH_QUOTE, 1'b0);
    end else if (brk < 84) begin
      send_text(8'($urandom), 1'b1);
    end else if (brk < 88) begin
      send_text(CH_BACKSLASH, 1'b0);
      send_text(8'($urandom), 1'b1);
    end else if (brk < 92) begin
      do b = 8'($urandom); while (escape_target(b) != 9'b0 || b == CH_U);
      send_text(CH_BACKSLASH, 1'b0);
      send_text(b, 1'b0);
    end else begin
      send_text(CH_BACKSLASH, 1'b0);
      send_text(CH_U, 1'b0);
      digits = $urandom_range(0, 3);
      for (int k = 0; k < digits; k++) send_text(hex_char(4'($urandom)), 1'b0);
      if (brk < 96) begin
        do b = 8'($urandom); while (hex_digit_of(b) != 5'b0);
        send_text(b, 1'b0);
      end else begin
        send_text(8'($urandom), 1'b1);
      end
    end
  endtask

  task automatic test_random_strings();
    int strings;
    strings = 0;
    while (sent_count < ITEM_TARGET) begin
      // Stray bytes and end marks between strings are ignored by the block.
      repeat ($urandom_range(0, 2)) begin
        send_text(8'($urandom_range(8'h23, 8'hFF)), 1'($urandom_range(0, 1)));
        noise_count++;
      end
      send_random_string();
      strings++;
      if (strings % 12 == 0) wait_drained();
    end
  endtask

  // Result checking, receiver stall patterns and the cycle limit.
  always @(posedge clk) begin : check_results
    res_t exp;
    cycle_count++;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (decoded_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: unexpected result byte=%02h status=%0d last=%0b",
                   out_ch.out_byte, out_ch.status, out_ch.last_of_run);
      end else begin
        exp = decoded_q.pop_front();
        results_checked++;
        if (out_ch.out_byte !== exp.out_byte || out_ch.status !== exp.status ||
            out_ch.last_of_run !== exp.last_of_run) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("ERROR: result %0d expected byte=%02h status=%0d last=%0b,",
                     results_checked, exp.out_byte, exp.status, exp.last_of_run,
                     " got byte=%02h status=%0d last=%0b",
                     out_ch.out_byte, out_ch.status, out_ch.last_of_run);
        end
      end
    end
    if (cycle_count % 40 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0:       out_ch.ready <= 1'b1;
      1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
      2:       out_ch.ready <= (cycle_count % 4 == 0);
      default: out_ch.ready <= 1'($urandom_range(0, 1));
    endcase
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL json_string_unescape_decoder_core");
      $finish;
    end
  end

  initial begin
    parse_phase       = PH_WAIT;
    hex_count         = 2'd0;
    cp_acc            = 16'd0;
    burst_left        = 0;
    sent_count        = 0;
    noise_count       = 0;
    results_checked   = 0;
    mismatch_count    = 0;
    strings_closed    = 0;
    error_exits       = 0;
    multibyte_seqs    = 0;
    drains            = 0;
    cycle_count       = 0;
    stall_mode        = 0;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.in_byte     <= 8'h00;
    in_ch.end_of_text <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_waiting_phase();
    test_plain_and_escapes();
    wait_drained();
    test_unicode_escapes();
    wait_drained();
    test_error_paths();
    wait_drained();
    test_random_strings();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Summary: %0d bytes and end marks sent (%0d stray), %0d results checked.",
             sent_count, noise_count, results_checked);
    $display("Summary: %0d strings closed, %0d error exits, %0d multi-byte sequences, %0d drains.",
             strings_closed, error_exits, multibyte_seqs, drains);
    if (mismatch_count == 0 && decoded_q.size() == 0) begin
      $display("PASS json_string_unescape_decoder_core");
    end else begin
      $display("%0d mismatches, %0d results still expected", mismatch_count,
               decoded_q.size());
      $display("FAIL json_string_unescape_decoder_core");
    end
    $finish;
  end

endmodule

// File: json_string_unescape_decoder_core.f
sv/jsud_pkg.sv
sv/jsud_in_if.sv
sv/jsud_out_if.sv
sv/jsud_decode.sv
sv/json_string_unescape_decoder_core.sv
test/tb_json_string_unescape_decoder_core.sv
